// File: rtl/ctbb_pkg.sv
// ----------------------------------------------------------------------------
// ctbb_pkg
// shared types and constants of the color threshold bounding box block
// ----------------------------------------------------------------------------
package ctbb_pkg;

  localparam int CoordW     = 11;
  localparam int SizeW      = 12;
  localparam int ColorW     = 8;
  localparam int CoordLimit = 2048;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 5;

  localparam logic [CoordW-1:0] CoordMax = {CoordW{1'b1}};

  localparam logic [SizeW-1:0]  RstFrameWidth  = 12'd320;
  localparam logic [SizeW-1:0]  RstFrameHeight = 12'd240;
  localparam logic [ColorW-1:0] RstRedMin      = 8'd128;
  localparam logic [ColorW-1:0] RstGreenMax    = 8'd64;
  localparam logic [ColorW-1:0] RstBlueMax     = 8'd64;

  typedef enum logic [2:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegRedMin      = 3'd2,
    RegGreenMax    = 3'd3,
    RegBlueMax     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              frame_start;
  } pix_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_right;
    logic [CoordW-1:0] box_bottom;
  } box_t;

  typedef struct packed {
    logic [SizeW-1:0]  frame_width;
    logic [SizeW-1:0]  frame_height;
    logic [ColorW-1:0] red_min;
    logic [ColorW-1:0] green_max;
    logic [ColorW-1:0] blue_max;
  } cfg_t;

  typedef struct packed {
    logic valid;
    box_t data;
  } res_wr_t;

endpackage

// File: rtl/ctbb_stream_if.sv
// ----------------------------------------------------------------------------
// ctbb_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface ctbb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ctbb_regs.sv
// ----------------------------------------------------------------------------
// ctbb_regs
// apb register file for frame size and color thresholds
// ----------------------------------------------------------------------------
module ctbb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ctbb_pkg::ApbAddrW-1:0]      paddr,
  input  logic [ctbb_pkg::ApbDataW-1:0]      pwdata,
  output logic [ctbb_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output ctbb_pkg::cfg_t                     cfg_o
);
  import ctbb_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegFrameWidth:  cfg_d.frame_width  = pwdata[SizeW-1:0];
        RegFrameHeight: cfg_d.frame_height = pwdata[SizeW-1:0];
        RegRedMin:      cfg_d.red_min      = pwdata[ColorW-1:0];
        RegGreenMax:    cfg_d.green_max    = pwdata[ColorW-1:0];
        RegBlueMax:     cfg_d.blue_max     = pwdata[ColorW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegFrameWidth:  prdata = ApbDataW'(cfg_q.frame_width);
      RegFrameHeight: prdata = ApbDataW'(cfg_q.frame_height);
      RegRedMin:      prdata = ApbDataW'(cfg_q.red_min);
      RegGreenMax:    prdata = ApbDataW'(cfg_q.green_max);
      RegBlueMax:     prdata = ApbDataW'(cfg_q.blue_max);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RstFrameWidth;
      cfg_q.frame_height <= RstFrameHeight;
      cfg_q.red_min      <= RstRedMin;
      cfg_q.green_max    <= RstGreenMax;
      cfg_q.blue_max     <= RstBlueMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/ctbb_track.sv
// ----------------------------------------------------------------------------
// ctbb_track
// pixel input register, raster counters and bounding box tracking
// ----------------------------------------------------------------------------
module ctbb_track #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctbb_stream_if.sink       pix,
  input  ctbb_pkg::cfg_t    cfg_i,
  input  logic              space_i,
  output ctbb_pkg::res_wr_t res_o
);
  import ctbb_pkg::*;

  localparam int LimW = (MAX_WIDTH  < CoordLimit) ? MAX_WIDTH  : CoordLimit;
  localparam int LimH = (MAX_HEIGHT < CoordLimit) ? MAX_HEIGHT : CoordLimit;
  localparam logic [SizeW-1:0] LimWv = SizeW'(LimW);
  localparam logic [SizeW-1:0] LimHv = SizeW'(LimH);

  logic s1_valid_q, s1_match_q, s1_start_q;
  logic fire, match;

  logic [CoordW-1:0] col_q, row_q, lcol_q, gcol_q, lrow_q, grow_q;
  logic [CoordW-1:0] col_d, row_d, lcol_d, gcol_d, lrow_d, grow_d;
  logic              any_q, any_d;

  logic [CoordW-1:0] e_col, e_row, e_lcol, e_gcol, e_lrow, e_grow;
  logic              e_any;
  logic [CoordW-1:0] n_lcol, n_gcol, n_lrow, n_grow;
  logic              n_any;
  logic [SizeW-1:0]  w_eff, h_eff, h_m1, lrow_s, grow_s;
  logic              last_col, last_pix;

  assign fire      = s1_valid_q & space_i;
  assign pix.ready = ~s1_valid_q | fire;
  assign match     = (pix.data.red >= cfg_i.red_min) &&
                     (pix.data.green <= cfg_i.green_max) &&
                     (pix.data.blue <= cfg_i.blue_max);

  always_comb begin
    // effective frame size
    if (cfg_i.frame_width == '0)      w_eff = SizeW'(1);
    else if (cfg_i.frame_width > LimWv) w_eff = LimWv;
    else                              w_eff = cfg_i.frame_width;
    if (cfg_i.frame_height == '0)      h_eff = SizeW'(1);
    else if (cfg_i.frame_height > LimHv) h_eff = LimHv;
    else                               h_eff = cfg_i.frame_height;
    h_m1 = h_eff - SizeW'(1);

    // frame start clears before the pixel counts
    if (s1_start_q) begin
      e_col = '0; e_row = '0; e_lcol = CoordMax; e_gcol = '0;
      e_lrow = CoordMax; e_grow = '0; e_any = 1'b0;
    end else begin
      e_col = col_q; e_row = row_q; e_lcol = lcol_q; e_gcol = gcol_q;
      e_lrow = lrow_q; e_grow = grow_q; e_any = any_q;
    end

    n_lcol = (s1_match_q && e_col < e_lcol) ? e_col : e_lcol;
    n_gcol = (s1_match_q && e_col > e_gcol) ? e_col : e_gcol;
    n_lrow = (s1_match_q && e_row < e_lrow) ? e_row : e_lrow;
    n_grow = (s1_match_q && e_row > e_grow) ? e_row : e_grow;
    n_any  = e_any | s1_match_q;

    last_col = ({1'b0, e_col} + SizeW'(1)) >= w_eff;
    last_pix = last_col && (({1'b0, e_row} + SizeW'(1)) >= h_eff);

    // rows past the frame saturate to the bottom row before the flip
    lrow_s = ({1'b0, n_lrow} >= h_eff) ? h_m1 : {1'b0, n_lrow};
    grow_s = ({1'b0, n_grow} >= h_eff) ? h_m1 : {1'b0, n_grow};

    res_o.valid = fire & last_pix;
    if (n_any) begin
      res_o.data.found      = 1'b1;
      res_o.data.box_left   = n_lcol;
      res_o.data.box_top    = CoordW'(h_m1 - lrow_s);
      res_o.data.box_right  = n_gcol;
      res_o.data.box_bottom = CoordW'(h_m1 - grow_s);
    end else begin
      res_o.data = '0;
    end

    if (last_pix) begin
      col_d = '0; row_d = '0; lcol_d = CoordMax; gcol_d = '0;
      lrow_d = CoordMax; grow_d = '0; any_d = 1'b0;
    end else begin
      lcol_d = n_lcol; gcol_d = n_gcol; lrow_d = n_lrow; grow_d = n_grow;
      any_d  = n_any;
      if (last_col) begin
        col_d = '0;
        row_d = e_row + CoordW'(1);
      end else begin
        col_d = e_col + CoordW'(1);
        row_d = e_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_match_q <= 1'b0;
      s1_start_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
      lcol_q <= CoordMax;
      gcol_q <= '0;
      lrow_q <= CoordMax;
      grow_q <= '0;
      any_q  <= 1'b0;
    end else begin
      if (pix.ready) begin
        s1_valid_q <= pix.valid;
        s1_match_q <= match;
        s1_start_q <= pix.data.frame_start;
      end
      if (fire) begin
        col_q  <= col_d;
        row_q  <= row_d;
        lcol_q <= lcol_d;
        gcol_q <= gcol_d;
        lrow_q <= lrow_d;
        grow_q <= grow_d;
        any_q  <= any_d;
      end
    end
  end

endmodule

// File: rtl/ctbb_out_buf.sv
// ----------------------------------------------------------------------------
// ctbb_out_buf
// result register with skid stage toward the box channel
// ----------------------------------------------------------------------------
module ctbb_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctbb_pkg::res_wr_t res_i,
  output logic              space_o,
  ctbb_stream_if.source     box
);
  import ctbb_pkg::*;

  logic out_valid_q, skid_valid_q, out_take;
  box_t out_q, skid_q;

  assign out_take  = out_valid_q & box.ready;
  assign space_o   = ~skid_valid_q;
  assign box.valid = out_valid_q;
  assign box.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_i.valid) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_i.valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_i.data;
      end else begin
        skid_q <= res_i.data;
      end
    end
  end

endmodule

// File: rtl/color_threshold_bounding_box_top.sv
// the last pixel word of a frame is registered in the input stage, then its box word in the result register
// throughput: one pixel word per cycle while the skid stage is empty
// a stalled box word is held in the result register, one more in the skid stage
// reset: asynchronous active low, clears counters, box, valids, config to defaults
// ----------------------------------------------------------------------------
// color_threshold_bounding_box_top
// color threshold match and bounding box of matching pixels per frame
// ----------------------------------------------------------------------------
module color_threshold_bounding_box_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctbb_pkg::ApbAddrW-1:0] paddr,
  input  logic [ctbb_pkg::ApbDataW-1:0] pwdata,
  output logic [ctbb_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  ctbb_stream_if.sink                   pix_i,
  ctbb_stream_if.source                 box_o
);
  import ctbb_pkg::*;

  cfg_t    cfg;
  res_wr_t res;
  logic    space;

  ctbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctbb_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix     (pix_i),
    .cfg_i   (cfg),
    .space_i (space),
    .res_o   (res)
  );

  ctbb_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .space_o (space),
    .box     (box_o)
  );

endmodule

// File: rtl/ctbb_checker.sv
// ----------------------------------------------------------------------------
// ctbb_checker
// port level checks of the box and pixel channels, bound to the top level
// ----------------------------------------------------------------------------
module ctbb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           pix_valid_i,
  input logic           pix_ready_i,
  input logic           box_valid_i,
  input logic           box_ready_i,
  input ctbb_pkg::box_t box_data_i
);
  import ctbb_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_i && !box_ready_i |=> box_valid_i && $stable(box_data_i))
    else $error("stalled box word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_i && !box_data_i.found |->
      box_data_i.box_left == '0 && box_data_i.box_top == '0 &&
      box_data_i.box_right == '0 && box_data_i.box_bottom == '0)
    else $error("empty frame with nonzero box");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_i && box_data_i.found |->
      box_data_i.box_left <= box_data_i.box_right &&
      box_data_i.box_bottom <= box_data_i.box_top)
    else $error("box corners out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(box_valid_i) |-> $past(pix_valid_i && pix_ready_i, 2))
    else $error("box word without a pixel two cycles before");

endmodule

bind color_threshold_bounding_box_top ctbb_checker u_ctbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .box_valid_i (box_o.valid),
  .box_ready_i (box_o.ready),
  .box_data_i  (box_o.data)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for color_threshold_bounding_box_top: pixel words go in
// through a bursty source, box words come out into a stalling sink, and each
// box word is checked field by field against a per-pixel tracker model kept
// here or a table row; a directed table runs first, then extreme frame sizes
// and thresholds, then random settings with mostly well-formed frames and some resyncs
// ----------------------------------------------------------------------------
module tb;
  import ctbb_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int IdleGap     = 8;
  localparam int RandomWords = 600;
  localparam int LongRun     = 300;

  typedef struct packed {
    pix_t pix;
    logic chk;
    box_t box;
  } dir_row_t;

  localparam box_t NoBox   = '0;
  localparam box_t FullBox = '{1'b1, 11'd0, 11'd1, 11'd2, 11'd0};

  // 3 x 2 frames with the reset thresholds
  dir_row_t dir_tab [25] = '{
    '{'{8'd0,   8'd255, 8'd255, 1'b1}, 1'b0, NoBox},
    '{'{8'd127, 8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd65,  8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd0,   8'd65,  1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd127, 8'd64,  8'd64,  1'b0}, 1'b1, NoBox},
    '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b0, NoBox},
    '{'{8'd128, 8'd64,  8'd64,  1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd0,   8'd64,  1'b0}, 1'b0, NoBox},
    '{'{8'd128, 8'd64,  8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd128, 8'd64,  8'd64,  1'b0}, 1'b1, FullBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b0, NoBox},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, NoBox},
    '{'{8'd200, 8'd10,  8'd20,  1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox},
    '{'{8'd130, 8'd60,  8'd60,  1'b0}, 1'b0, NoBox},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NoBox}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                sink_ready = 1'b0;

  ctbb_stream_if #(.T(pix_t)) pix_if ();
  ctbb_stream_if #(.T(box_t)) box_if ();

  assign box_if.ready = sink_ready;

  color_threshold_bounding_box_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .box_o   (box_if)
  );

  always #2 clk_i = ~clk_i;

  // tracker model state and its copy of the registers
  cfg_t              model_cfg;
  logic [CoordW-1:0] col_cnt, row_cnt, col_lo, col_hi, row_lo, row_hi;
  logic              hit;

  box_t pending_boxes [$];
  box_t want_box;

  int cyc;
  int mismatches;
  int box_count;
  int found_count;
  int pixels_sent;
  int random_words;
  int settings_count;
  int burst_left;
  int stall_mode;
  int stall_left;

  function automatic int eff_size(input logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > CoordLimit) return CoordLimit;
    return int'(v);
  endfunction

  function automatic logic [CoordW-1:0] flip_row(input logic [CoordW-1:0] row, input int h);
    int r;
    r = int'(row);
    if (r >= h) r = h - 1;
    return CoordW'(h - 1 - r);
  endfunction

  task automatic clear_track();
    col_cnt = '0;
    row_cnt = '0;
    col_lo  = CoordMax;
    col_hi  = '0;
    row_lo  = CoordMax;
    row_hi  = '0;
    hit     = 1'b0;
  endtask

  task automatic track_pixel(input pix_t p, output bit done, output box_t res);
    int w;
    int h;
    bit last_col;
    w    = eff_size(model_cfg.frame_width);
    h    = eff_size(model_cfg.frame_height);
    done = 1'b0;
    res  = '0;
    if (p.frame_start) clear_track();
    if (p.red >= model_cfg.red_min && p.green <= model_cfg.green_max &&
        p.blue <= model_cfg.blue_max) begin
      if (col_cnt < col_lo) col_lo = col_cnt;
      if (col_cnt > col_hi) col_hi = col_cnt;
      if (row_cnt < row_lo) row_lo = row_cnt;
      if (row_cnt > row_hi) row_hi = row_cnt;
      hit = 1'b1;
    end
    last_col = int'(col_cnt) + 1 >= w;
    if (last_col && int'(row_cnt) + 1 >= h) begin
      done = 1'b1;
      if (hit) begin
        res.found      = 1'b1;
        res.box_left   = col_lo;
        res.box_top    = flip_row(row_lo, h);
        res.box_right  = col_hi;
        res.box_bottom = flip_row(row_hi, h);
      end
      clear_track();
    end else if (last_col) begin
      col_cnt = '0;
      row_cnt = row_cnt + CoordW'(1);
    end else begin
      col_cnt = col_cnt + CoordW'(1);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch on box word %0d: %s", cyc, box_count, msg);
    mismatches++;
  endtask

  function automatic logic [ColorW-1:0] near(input logic [ColorW-1:0] t);
    int v;
    v = int'(t) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ColorW'(v);
  endfunction

  function automatic pix_t gen_pixel(input bit at_start);
    pix_t p;
    int   kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      p.red   = ColorW'($urandom_range(int'(model_cfg.red_min), 255));
      p.green = ColorW'($urandom_range(0, int'(model_cfg.green_max)));
      p.blue  = ColorW'($urandom_range(0, int'(model_cfg.blue_max)));
    end else if (kind < 6) begin
      p.red   = near(model_cfg.red_min);
      p.green = near(model_cfg.green_max);
      p.blue  = near(model_cfg.blue_max);
    end else begin
      p.red   = ColorW'($urandom_range(0, 255));
      p.green = ColorW'($urandom_range(0, 255));
      p.blue  = ColorW'($urandom_range(0, 255));
    end
    // mostly marked frame starts, now and then a resync mid-frame
    p.frame_start = at_start ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 39) == 0);
    return p;
  endfunction

  function automatic logic [ApbDataW-1:0] pick_size(input int hi);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return ApbDataW'($urandom_range(9, 24));
    return ApbDataW'($urandom_range(1, hi));
  endfunction

  function automatic logic [ApbDataW-1:0] pick_level();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return '0;
    if (k < 4) return ApbDataW'(255);
    return ApbDataW'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ApbAddrW'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      RegFrameWidth:  model_cfg.frame_width  = value[SizeW-1:0];
      RegFrameHeight: model_cfg.frame_height = value[SizeW-1:0];
      RegRedMin:      model_cfg.red_min      = value[ColorW-1:0];
      RegGreenMax:    model_cfg.green_max    = value[ColorW-1:0];
      RegBlueMax:     model_cfg.blue_max     = value[ColorW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [ApbDataW-1:0] w, input logic [ApbDataW-1:0] h,
                           input logic [ApbDataW-1:0] r, input logic [ApbDataW-1:0] g,
                           input logic [ApbDataW-1:0] b);
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
    write_reg(RegRedMin, r);
    write_reg(RegGreenMax, g);
    write_reg(RegBlueMax, b);
    settings_count++;
  endtask

  task automatic send_pixel(input pix_t p, input bit typed, input box_t typed_box);
    bit   done;
    box_t res;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    track_pixel(p, done, res);
    if (done) pending_boxes.push_back(typed ? typed_box : res);
    else if (typed) report_mismatch("table row expects a box word but model ends no frame");
    pix_if.data  = p;
    pix_if.valid = 1'b1;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  // hold off until every box word is out, then let the pipeline drain
  task automatic wait_idle();
    pix_if.valid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    repeat (IdleGap) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("timeout after %0d cycles, %0d box words outstanding", cyc,
               pending_boxes.size());
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && box_if.valid && box_if.ready) begin
      box_count++;
      if (box_if.data.found) found_count++;
      if (pending_boxes.size() == 0) begin
        report_mismatch("box word with none expected");
      end else begin
        want_box = pending_boxes.pop_front();
        if (box_if.data.found !== want_box.found)
          report_mismatch($sformatf("found %0b want %0b", box_if.data.found, want_box.found));
        if (box_if.data.box_left !== want_box.box_left)
          report_mismatch($sformatf("box_left %0d want %0d", box_if.data.box_left,
                                    want_box.box_left));
        if (box_if.data.box_top !== want_box.box_top)
          report_mismatch($sformatf("box_top %0d want %0d", box_if.data.box_top,
                                    want_box.box_top));
        if (box_if.data.box_right !== want_box.box_right)
          report_mismatch($sformatf("box_right %0d want %0d", box_if.data.box_right,
                                    want_box.box_right));
        if (box_if.data.box_bottom !== want_box.box_bottom)
          report_mismatch($sformatf("box_bottom %0d want %0d", box_if.data.box_bottom,
                                    want_box.box_bottom));
      end
    end
  end

  // sink stall pattern: always ready, coin flip, or ready when cyc is a multiple of 5
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      2:       sink_ready = ($urandom_range(0, 1) == 1);
      3:       sink_ready = (cyc % 5 == 0);
      default: sink_ready = 1'b1;
    endcase
  end

  initial begin
    pix_t p;
    int   n;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    burst_left   = 0;
    model_cfg    = '{RstFrameWidth, RstFrameHeight, RstRedMin, RstGreenMax, RstBlueMax};
    clear_track();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_all(3, 2, 128, 64, 64);
    foreach (dir_tab[i]) send_pixel(dir_tab[i].pix, dir_tab[i].chk, dir_tab[i].box);
    wait_idle();

    // oversized width register, everything matches, row cut short by a narrower width
    write_all(4095, 1, 0, 255, 255);
    for (int i = 0; i < LongRun; i++) begin
      p = gen_pixel(1'b0);
      p.frame_start = (i == 0);
      send_pixel(p, 1'b0, NoBox);
    end
    wait_idle();
    write_reg(RegFrameWidth, 1);
    p = gen_pixel(1'b0);
    p.frame_start = 1'b0;
    send_pixel(p, 1'b0, NoBox);
    wait_idle();

    // oversized height, zero width register, pure red only, rows past a shorter height
    write_all(0, 4095, 255, 0, 0);
    for (int i = 0; i < LongRun; i++) begin
      p = gen_pixel(1'b0);
      if (i == 0 || i == LongRun - 1) begin
        p.red   = 8'd255;
        p.green = 8'd0;
        p.blue  = 8'd0;
      end
      p.frame_start = (i == 0);
      send_pixel(p, 1'b0, NoBox);
    end
    wait_idle();
    write_reg(RegFrameHeight, 1);
    p = gen_pixel(1'b0);
    p.frame_start = 1'b0;
    send_pixel(p, 1'b0, NoBox);
    wait_idle();

    // phases may stop mid-frame, so sizes also change inside a frame
    while (random_words < RandomWords) begin
      write_all(pick_size(8), pick_size(6), pick_level(), pick_level(), pick_level());
      n = $urandom_range(20, 150);
      repeat (n) send_pixel(gen_pixel(col_cnt == '0 && row_cnt == '0), 1'b0, NoBox);
      random_words += n;
      wait_idle();
    end

    $display("covered %0d pixel words (%0d random) over %0d register settings",
             pixels_sent, random_words, settings_count);
    $display("checked %0d box words, %0d with a match, %0d mismatches",
             box_count, found_count, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ctbb_pkg.sv
rtl/ctbb_stream_if.sv
rtl/ctbb_regs.sv
rtl/ctbb_track.sv
rtl/ctbb_out_buf.sv
rtl/color_threshold_bounding_box_top.sv
rtl/ctbb_checker.sv
tb/tb.sv
